// ===== src/tte_pkg.sv =====
// Shared types, character codes and command codes for the terminal cursor engine.
// Used by tte_step, tte_outq and text_terminal_cursor_escape_engine_unit.
`timescale 1ns / 1ps

package tte_pkg;

	// Character codes
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_K        = 8'h4B;
	localparam logic [7:0] CH_D        = 8'h44;
	localparam logic [7:0] CH_C        = 8'h43;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	// Drawing commands
	localparam logic [2:0] CMD_GLYPH   = 3'd0;
	localparam logic [2:0] CMD_CLEAR   = 3'd1;
	localparam logic [2:0] CMD_RESTORE = 3'd2;
	localparam logic [2:0] CMD_CURSOR  = 3'd3;
	localparam logic [2:0] CMD_SCROLL  = 3'd4;

	// Escape parser phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ESC  = 2'd1;
	localparam logic [1:0] PH_CSI  = 2'd2;

	// Configuration register indexes
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [8:0] COLUMNS_RESET = 9'd80;
	localparam logic [7:0] ROWS_RESET    = 8'd30;
	localparam logic [8:0] COLUMNS_MAX   = 9'd256;
	localparam logic [7:0] ROWS_MAX      = 8'd128;

	// Tab stops; the column is divided by a reciprocal multiply (exact for 8-bit columns).
	localparam int TAB_STOP  = 8;
	localparam int TAB_SHIFT = 16;
	localparam int TAB_RECIP = (2 ** TAB_SHIFT + TAB_STOP - 1) / TAB_STOP;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] column;
		logic [6:0] line;
		logic [7:0] glyph_code;
	} cmd_t;

	typedef struct packed {
		cmd_t [2:0] cmds;
		logic [1:0] count;
	} group_t;

	typedef struct packed {
		logic [7:0]  col;
		logic [6:0]  line;
		logic [1:0]  phase;
		logic [15:0] num;
		logic        shown;
	} state_t;

	typedef struct packed {
		logic [7:0] col;
		logic [6:0] line;
		logic       scroll;
	} place_t;

	function automatic cmd_t mk_cmd(input logic [2:0] command, input logic [7:0] column,
	                                input logic [6:0] line, input logic [7:0] glyph_code);
		cmd_t r;
		r.command    = command;
		r.column     = column;
		r.line       = line;
		r.glyph_code = glyph_code;
		return r;
	endfunction

	// Wrap at the column limit, then scroll when the line falls off the screen.
	function automatic place_t place_cursor(input logic [16:0] col, input logic [7:0] line,
	                                        input logic [8:0] cols, input logic [7:0] rows);
		place_t      r;
		logic [16:0] c;
		logic [7:0]  l;
		c = col;
		l = line;
		if (c >= 17'(cols)) begin
			c = '0;
			l = l + 8'd1;
		end
		r.scroll = (l >= rows);
		if (r.scroll) begin
			l = l - 8'd1;
		end
		r.col  = c[7:0];
		r.line = l[6:0];
		return r;
	endfunction

endpackage

// ===== src/tte_step.sv =====
// Per-character decode: escape parser, cursor motion and the list of drawing commands.
// Purely combinational; depends on tte_pkg.
`timescale 1ns / 1ps

module tte_step (
	input  logic [7:0]      char_code,
	input  logic            end_of_string,
	input  tte_pkg::state_t st,
	input  logic [8:0]      cols,
	input  logic [7:0]      rows,
	output tte_pkg::state_t nx,
	output tte_pkg::group_t grp
);
	import tte_pkg::*;

	logic        plain;
	logic        do_place;
	logic [16:0] tgt_col;
	logic [7:0]  tgt_line;
	logic [1:0]  n;
	place_t      pl;
	logic [15:0] k;
	logic [19:0] num_mac;
	logic [15:0] num_sat;
	logic [24:0] tab_prod;
	logic [8:0]  tab_q;
	logic [16:0] tab_next;
	logic        is_digit;

	assign k        = (st.num == '0) ? 16'd1 : st.num;
	assign num_mac  = 20'(st.num) * 20'd10 + 20'(char_code - CH_ZERO);
	assign num_sat  = (num_mac > 20'd65535) ? 16'hFFFF : num_mac[15:0];
	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign tab_prod = 25'(st.col) * 25'(TAB_RECIP);
	assign tab_q    = tab_prod[24:16];
	assign tab_next = (17'(tab_q) + 17'd1) * 17'(TAB_STOP);

	always_comb begin
		nx       = st;
		grp      = '0;
		n        = '0;
		plain    = 1'b0;
		do_place = 1'b0;
		tgt_col  = '0;
		tgt_line = '0;
		pl       = '0;

		if (char_code == CH_ESC) begin
			nx.phase = PH_ESC;
		end else if (st.phase == PH_ESC) begin
			if (char_code == CH_LBRACKET) begin
				nx.phase = PH_CSI;
				nx.num   = '0;
			end else begin
				nx.phase = PH_IDLE;
				plain    = 1'b1;
			end
		end else if (st.phase == PH_CSI) begin
			if (is_digit) begin
				nx.num = num_sat;
			end else begin
				if (char_code == CH_K) begin
					grp.cmds[n] = mk_cmd(CMD_CLEAR, st.col, st.line, 8'd0);
					n = n + 2'd1;
				end else if (char_code == CH_D) begin
					if (st.shown) begin
						grp.cmds[n] = mk_cmd(CMD_RESTORE, st.col, st.line, 8'd0);
						n = n + 2'd1;
					end
					nx.col = (16'(st.col) > k) ? 8'(16'(st.col) - k) : 8'd0;
				end else if (char_code == CH_C) begin
					if (st.shown) begin
						grp.cmds[n] = mk_cmd(CMD_RESTORE, st.col, st.line, 8'd0);
						n = n + 2'd1;
					end
					do_place = 1'b1;
					tgt_col  = 17'(st.col) + 17'(k);
					tgt_line = 8'(st.line);
				end
				nx.phase = PH_IDLE;
			end
		end else begin
			nx.phase = PH_IDLE;
			plain    = 1'b1;
		end

		if (plain) begin
			if (char_code >= CH_SPACE) begin
				grp.cmds[n] = mk_cmd(CMD_GLYPH, st.col, st.line, char_code);
				n = n + 2'd1;
				nx.shown = 1'b0;
				do_place = 1'b1;
				tgt_col  = 17'(st.col) + 17'd1;
				tgt_line = 8'(st.line);
			end else if (char_code == CH_LF || char_code == CH_CR || char_code == CH_TAB) begin
				if (st.shown) begin
					grp.cmds[n] = mk_cmd(CMD_RESTORE, st.col, st.line, 8'd0);
					n = n + 2'd1;
				end
				do_place = 1'b1;
				tgt_line = 8'(st.line);
				if (char_code == CH_LF) begin
					tgt_col  = '0;
					tgt_line = 8'(st.line) + 8'd1;
				end else if (char_code == CH_CR) begin
					tgt_col = '0;
				end else begin
					tgt_col = tab_next;
				end
			end
		end

		if (do_place) begin
			pl      = place_cursor(tgt_col, tgt_line, cols, rows);
			nx.col  = pl.col;
			nx.line = pl.line;
			if (pl.scroll) begin
				grp.cmds[n] = mk_cmd(CMD_SCROLL, 8'd0, pl.line, 8'd0);
				n = n + 2'd1;
			end
		end

		// The cursor is drawn again at the end of every string.
		if (end_of_string) begin
			grp.cmds[n] = mk_cmd(CMD_CURSOR, nx.col, nx.line, 8'd0);
			n = n + 2'd1;
			nx.shown = 1'b1;
			nx.phase = PH_IDLE;
			nx.num   = '0;
		end

		grp.count = n;
	end

endmodule

// ===== src/tte_outq.sv =====
// Result register holding the commands of one character, sent one beat per cycle while m_ready is high.
// Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  tte_pkg::group_t grp_in,
	input  logic            m_ready,
	output logic            m_valid,
	output tte_pkg::cmd_t   m_cmd,
	output logic            m_last,
	output logic            free
);
	import tte_pkg::*;

	group_t     grp_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       last_beat;

	assign last_beat = (idx_q == grp_q.count - 2'd1);
	assign free      = !valid_q || (m_ready && last_beat);
	assign m_valid   = valid_q;
	assign m_last    = last_beat;

	always_comb begin
		case (idx_q)
			2'd0:    m_cmd = grp_q.cmds[0];
			2'd1:    m_cmd = grp_q.cmds[1];
			default: m_cmd = grp_q.cmds[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && m_ready) begin
			if (last_beat) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result group loaded over undelivered beats");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> grp_in.count != 2'd0)
		else $error("empty result group loaded");
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < grp_q.count)
		else $error("beat index beyond result group");
	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && m_ready && last_beat && !load |=> !valid_q)
		else $error("result register still valid after last beat");
`endif

endmodule

// ===== src/text_terminal_cursor_escape_engine_unit.sv =====
// Top level of the terminal cursor engine: input stage, cursor and parser state,
// configuration registers. Depends on tte_pkg, tte_step and tte_outq.
`timescale 1ns / 1ps
//
//  Channel   Direction  Beat contents
//  s_*       in         tdata[7:0] char_code, tlast end_of_string
//  m_*       out        tuser[2:0] command, tdata column/line/glyph_code, tlast last
//  cfg_*     in         write of columns (index 0) or rows (index 1)
//
//  A character is captured in the input register and decoded from there,
//  loading its zero to three commands into the result register once that is free.
//  Commands leave one beat per cycle while m_tready is high.
//  A new character is taken in the same cycle as the previous one's last command leaves.
//  Reset clears the cursor to the top left, shows it, and idles the parser.

module text_terminal_cursor_escape_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] column, [14:8] line, [22:15] glyph_code, [23] zero
	output logic [2:0]  m_tuser,   // [2:0] command
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_wdata
);
	import tte_pkg::*;

	logic [8:0] cols_q;
	logic [7:0] rows_q;
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;
	state_t     st_q;
	state_t     st_nx;
	group_t     grp;
	logic       grp_free;
	logic       fire;
	cmd_t       out_cmd;

	// Registers hold the range-limited value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLUMNS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS: begin
					if (cfg_wdata == '0) begin
						cols_q <= 9'd1;
					end else if (cfg_wdata > COLUMNS_MAX) begin
						cols_q <= COLUMNS_MAX;
					end else begin
						cols_q <= cfg_wdata;
					end
				end
				default: begin
					if (cfg_wdata[7:0] == '0) begin
						rows_q <= 8'd1;
					end else if (cfg_wdata[7:0] > ROWS_MAX) begin
						rows_q <= ROWS_MAX;
					end else begin
						rows_q <= cfg_wdata[7:0];
					end
				end
			endcase
		end
	end

	// A character with no commands retires without the result register.
	assign fire     = valid_s1 && (grp.count == 2'd0 || grp_free);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.col   <= '0;
			st_q.line  <= '0;
			st_q.phase <= PH_IDLE;
			st_q.num   <= '0;
			st_q.shown <= 1'b1;
		end else if (fire) begin
			st_q <= st_nx;
		end
	end

	tte_step u_step (
		.char_code     (char_s1),
		.end_of_string (eos_s1),
		.st            (st_q),
		.cols          (cols_q),
		.rows          (rows_q),
		.nx            (st_nx),
		.grp           (grp)
	);

	tte_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && grp.count != 2'd0),
		.grp_in  (grp),
		.m_ready (m_tready),
		.m_valid (m_tvalid),
		.m_cmd   (out_cmd),
		.m_last  (m_tlast),
		.free    (grp_free)
	);

	assign m_tdata = {1'b0, out_cmd.glyph_code, out_cmd.line, out_cmd.column};
	assign m_tuser = out_cmd.command;

`ifndef SYNTHESIS
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(char_s1) && $stable(eos_s1))
		else $error("input stage lost a waiting character");
	a_eos_shows_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eos_s1 |=> st_q.shown && st_q.phase == PH_IDLE && st_q.num == '0)
		else $error("end of string did not redraw cursor and idle the parser");
	a_idle_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && st_q.phase == PH_IDLE && char_s1 != CH_ESC |=> st_q.phase == PH_IDLE)
		else $error("parser left idle without an escape byte");
`endif

endmodule

// ===== bench/tb_text_terminal_cursor_escape_engine_unit.sv =====
// Self-checking bench for the terminal cursor engine: streams characters in, predicts the
// drawing commands with its own cursor and escape parser model, and checks every beat.
// Depends on tte_pkg and text_terminal_cursor_escape_engine_unit.
`timescale 1ns / 1ps

module tb_text_terminal_cursor_escape_engine_unit;
	import tte_pkg::*;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] column;
		logic [6:0] line;
		logic [7:0] glyph_code;
		logic       last;
	} draw_cmd_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [8:0]  cfg_wdata = '0;

	// Predicted screen state, kept in step with the accepted characters.
	logic [8:0]  columns_reg = COLUMNS_RESET;
	logic [7:0]  rows_reg    = ROWS_RESET;
	logic [7:0]  cur_col     = '0;
	logic [6:0]  cur_line    = '0;
	logic [1:0]  esc_phase   = PH_IDLE;
	logic [15:0] esc_num     = '0;
	logic        cursor_on   = 1'b1;

	draw_cmd_t expected_cmds[$];

	int fail_count    = 0;
	int chars_sent    = 0;
	int chars_taken   = 0;
	int cmds_checked  = 0;
	int screen_setups = 0;
	int cmd_count[0:4] = '{default: 0};

	// Sender burst control and receiver stall control.
	bit gaps_on       = 1'b0;
	int burst_left    = 0;
	int stall_pct     = 0;
	int long_hold_req = 0;
	int hold_left     = 0;

	text_terminal_cursor_escape_engine_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_text_terminal_cursor_escape_engine_unit: FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void add_cmd(logic [2:0] command, int col, int ln, logic [7:0] glyph);
		draw_cmd_t d;
		d.command    = command;
		d.column     = col[7:0];
		d.line       = ln[6:0];
		d.glyph_code = glyph;
		d.last       = 1'b0;
		expected_cmds.push_back(d);
	endfunction

	function automatic void restore_under_cursor();
		if (cursor_on) begin
			add_cmd(CMD_RESTORE, cur_col, cur_line, 8'h00);
		end
	endfunction

	// Wrap at the right edge, then scroll by at most one line even on a shrunk screen.
	function automatic void move_cursor(int col, int ln);
		int eff_cols;
		int eff_rows;
		eff_cols = (columns_reg == 0) ? 1 : ((columns_reg > 256) ? 256 : int'(columns_reg));
		eff_rows = (rows_reg == 0) ? 1 : ((rows_reg > 128) ? 128 : int'(rows_reg));
		if (col >= eff_cols) begin
			col = 0;
			ln  = ln + 1;
		end
		if (ln + 1 > eff_rows) begin
			ln = ln - 1;
			add_cmd(CMD_SCROLL, 0, ln, 8'h00);
		end
		cur_col  = col[7:0];
		cur_line = ln[6:0];
	endfunction

	function automatic void predict_char(logic [7:0] c, logic eos);
		logic plain;
		int   k;
		int   v;
		int   first;
		plain = 1'b0;
		first = expected_cmds.size();
		if (c == CH_ESC) begin
			esc_phase = PH_ESC;
		end else if (esc_phase == PH_ESC) begin
			if (c == CH_LBRACKET) begin
				esc_phase = PH_CSI;
				esc_num   = '0;
			end else begin
				esc_phase = PH_IDLE;
				plain     = 1'b1;
			end
		end else if (esc_phase == PH_CSI) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				v = int'(esc_num) * 10 + int'(c) - int'(CH_ZERO);
				esc_num = (v > 65535) ? 16'hFFFF : v[15:0];
			end else begin
				k = (esc_num == 0) ? 1 : int'(esc_num);
				if (c == CH_K) begin
					add_cmd(CMD_CLEAR, cur_col, cur_line, 8'h00);
				end else if (c == CH_D) begin
					restore_under_cursor();
					cur_col = (int'(cur_col) > k) ? 8'(int'(cur_col) - k) : 8'd0;
				end else if (c == CH_C) begin
					restore_under_cursor();
					move_cursor(int'(cur_col) + k, cur_line);
				end
				esc_phase = PH_IDLE;
			end
		end else begin
			esc_phase = PH_IDLE;
			plain     = 1'b1;
		end

		if (plain) begin
			if (c >= CH_SPACE) begin
				add_cmd(CMD_GLYPH, cur_col, cur_line, c);
				cursor_on = 1'b0;
				move_cursor(int'(cur_col) + 1, cur_line);
			end else if (c == CH_LF) begin
				restore_under_cursor();
				move_cursor(0, int'(cur_line) + 1);
			end else if (c == CH_CR) begin
				restore_under_cursor();
				move_cursor(0, cur_line);
			end else if (c == CH_TAB) begin
				k = int'(cur_col) + TAB_STOP - (int'(cur_col) % TAB_STOP);
				restore_under_cursor();
				move_cursor(k, cur_line);
			end
		end

		if (eos) begin
			add_cmd(CMD_CURSOR, cur_col, cur_line, 8'h00);
			cursor_on = 1'b1;
			esc_phase = PH_IDLE;
			esc_num   = '0;
		end

		if (expected_cmds.size() > first) begin
			expected_cmds[expected_cmds.size() - 1].last = 1'b1;
		end
	endfunction

	// ---------------------------------------------------------------- checker

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Characters are predicted before results are checked, so a beat never races its own item.
	always @(posedge clk) begin
		draw_cmd_t want;
		if (s_tvalid && s_tready) begin
			predict_char(s_tdata, s_tlast);
			chars_taken++;
		end
		if (m_tvalid && m_tready) begin
			if (m_tuser <= CMD_SCROLL) begin
				cmd_count[m_tuser]++;
			end
			if (expected_cmds.size() == 0) begin
				$error("command beat %0d at column %0d line %0d with nothing expected",
				       m_tuser, m_tdata[7:0], m_tdata[14:8]);
				fail_count++;
			end else begin
				want = expected_cmds.pop_front();
				check_field("command", want.command, m_tuser);
				check_field("column", want.column, m_tdata[7:0]);
				check_field("line", want.line, m_tdata[14:8]);
				check_field("glyph_code", want.glyph_code, m_tdata[22:15]);
				check_field("last", want.last, m_tlast);
				cmds_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req > 0) begin
				hold_left     = long_hold_req;
				long_hold_req = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready  <= 1'b0;
				hold_left = $urandom_range(0, 4);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// Entered and left at a rising edge; valid stays high so a burst runs back to back.
	task automatic send_char(input logic [7:0] c, input logic eos);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
	endtask

	// ESC [ with n_digits decimal digits of value (leading zeros kept) and a final byte.
	task automatic send_csi(input int n_digits, input int value, input logic [7:0] final_byte,
	                        input logic eos);
		int scale;
		int i;
		send_char(CH_ESC, 1'b0);
		send_char(CH_LBRACKET, 1'b0);
		scale = 1;
		for (i = 1; i < n_digits; i++) begin
			scale = scale * 10;
		end
		for (i = 0; i < n_digits; i++) begin
			send_char(8'(int'(CH_ZERO) + (value / scale) % 10), 1'b0);
			scale = scale / 10;
		end
		send_char(final_byte, eos);
	endtask

	// Stops offering, waits out every expected beat, then lets the pipeline settle.
	task automatic wait_drained();
		int guard;
		s_tvalid   <= 1'b0;
		burst_left = 0;
		guard      = 0;
		@(posedge clk);
		while (expected_cmds.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [8:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_COLUMNS) begin
			columns_reg = value;
		end else begin
			rows_reg = value[7:0];
		end
	endtask

	task automatic set_screen(input logic [8:0] cols, input logic [8:0] lines);
		wait_drained();
		write_register(REG_COLUMNS, cols);
		write_register(REG_ROWS, lines);
		screen_setups++;
	endtask

	// Mostly printable text and well-formed CSI sequences, with some broken ones.
	task automatic send_random_item();
		int         pick;
		int         n;
		logic       eos;
		logic [7:0] fin;
		pick = $urandom_range(0, 99);
		eos  = ($urandom_range(0, 7) == 0);
		if (pick < 45) begin
			send_char(8'($urandom_range(32, 255)), eos);
		end else if (pick < 57) begin
			case ($urandom_range(0, 3))
				0: send_char(CH_CR, eos);
				1: send_char(CH_LF, eos);
				2: send_char(CH_TAB, eos);
				default: send_char(8'($urandom_range(0, 31)), eos);
			endcase
		end else if (pick < 87) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
			case ($urandom_range(0, 3))
				0: fin = CH_K;
				1: fin = CH_D;
				2: fin = CH_C;
				default: fin = 8'($urandom_range(0, 255));
			endcase
			send_csi(n, $urandom_range(0, (10 ** n) - 1), fin, eos);
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					send_char(CH_ESC, 1'b0);
					send_char(8'($urandom_range(0, 255)), eos);
				end
				1: begin
					send_char(CH_ESC, 1'b0);
					send_csi(1, $urandom_range(0, 9), CH_C, eos);
				end
				2: begin
					// End of string in the middle of the parameter.
					send_char(CH_ESC, 1'b0);
					send_char(CH_LBRACKET, 1'b0);
					send_char(8'(int'(CH_ZERO) + $urandom_range(0, 9)), 1'b1);
				end
				default: send_char(8'($urandom_range(0, 255)), 1'b1);
			endcase
		end
	endtask

	task automatic run_phase(input logic [8:0] cols, input logic [8:0] lines, input int n_chars,
	                         input bit gaps, input int stall, input int hold);
		int target;
		set_screen(cols, lines);
		gaps_on       = gaps;
		stall_pct     = stall;
		long_hold_req = hold;
		target        = chars_sent + n_chars;
		while (chars_sent < target) begin
			send_random_item();
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_plain_characters();
		gaps_on   = 1'b0;
		stall_pct = 0;
		send_char(8'h41, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_TAB, 1'b0);
		send_char(8'h01, 1'b0);
		send_char(CH_CR, 1'b0);
		send_char(CH_LF, 1'b1);
		send_char(8'h00, 1'b1);
		send_char(CH_TAB, 1'b0);
		wait_drained();
	endtask

	task automatic test_escape_sequences();
		gaps_on   = 1'b1;
		stall_pct = 30;
		send_csi(2, 12, CH_D, 1'b0);
		send_csi(0, 0, CH_C, 1'b0);
		send_csi(0, 0, CH_K, 1'b0);
		send_char(CH_ESC, 1'b0);
		send_char(8'h78, 1'b0);
		send_char(CH_ESC, 1'b0);
		send_csi(0, 0, 8'h7A, 1'b1);
		wait_drained();
	endtask

	task automatic test_register_limits();
		// Written above the maximum, so the screen is 256 by 128.
		set_screen(9'd511, 9'd255);
		send_char(CH_CR, 1'b0);
		send_csi(3, 255, CH_C, 1'b0);
		send_char(8'h5A, 1'b0);
		send_csi(6, 700000, CH_C, 1'b1);
		set_screen(9'd1, 9'd1);
		send_char(8'h51, 1'b0);
		send_char(CH_LF, 1'b1);
		set_screen(9'd0, 9'd0);
		send_char(CH_TAB, 1'b0);
		send_char(8'h52, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		run_phase(9'd80, 9'd30, 40, 1'b1, 20, 0);
		run_phase(9'd511, 9'd255, 40, 1'b0, 0, 0);
		run_phase(9'd1, 9'd128, 160, 1'b1, 25, 0);
		// The cursor sits far below the new bottom line here.
		run_phase(9'd17, 9'd5, 40, 1'b1, 35, 0);
		run_phase(9'd0, 9'd0, 30, 1'b1, 15, 0);
		run_phase(9'd256, 9'd3, 50, 1'b1, 60, 0);
	endtask

	task automatic test_output_backpressure();
		run_phase(9'd9, 9'd128, 40, 1'b0, 10, 300);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_characters();
		test_escape_sequences();
		test_register_limits();
		test_random_traffic();
		test_output_backpressure();

		wait_drained();
		if (expected_cmds.size() != 0) begin
			$error("%0d expected commands never came out", expected_cmds.size());
			fail_count++;
		end
		$display("Sent %0d characters, checked %0d command beats over %0d screen sizes.",
		         chars_taken, cmds_checked, screen_setups);
		$display("Beat mix: %0d glyph, %0d clear, %0d restore, %0d cursor, %0d scroll.",
		         cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4]);
		if (fail_count == 0) begin
			$display("tb_text_terminal_cursor_escape_engine_unit: PASS");
		end else begin
			$display("tb_text_terminal_cursor_escape_engine_unit: FAIL");
		end
		$finish;
	end

endmodule

// ===== text_terminal_cursor_escape_engine_unit.f =====
src/tte_pkg.sv
src/tte_step.sv
src/tte_outq.sv
src/text_terminal_cursor_escape_engine_unit.sv
bench/tb_text_terminal_cursor_escape_engine_unit.sv
